### src/private_address_classifier_defines.svh
// ----------------------------------------------------------------------------
// private_address_classifier_defines
// Assertion macros for the private address classifier. They expand to
// concurrent assertions in simulation and to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PRIVATE_ADDRESS_CLASSIFIER_DEFINES_SVH
`define PRIVATE_ADDRESS_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a consequence in the same cycle as its cause.
`define PAC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define PAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PAC_ASSERT_SAME(lbl, ante, cons, msg)
`define PAC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### src/pac_pkg.sv
// ----------------------------------------------------------------------------
// pac_pkg
// Shared types and codes of the private address classifier.
// ----------------------------------------------------------------------------
package pac_pkg;

  // Address family codes
  localparam logic FAM_V4 = 1'b0;
  localparam logic FAM_V6 = 1'b1;

  // Item action codes
  localparam logic ACT_LOAD     = 1'b0;
  localparam logic ACT_CLASSIFY = 1'b1;

  // Largest legal prefix lengths
  localparam logic [7:0] V4_PREFIX_MAX = 8'd32;
  localparam logic [7:0] V6_PREFIX_MAX = 8'd128;

  // Link between neighboring cells: search token and accumulated hit
  typedef struct packed {
    logic tok;
    logic hit;
  } pac_link_t;

endpackage

### src/pac_fixed.sv
// ----------------------------------------------------------------------------
// pac_fixed
// Matches an address against the fixed private IPv4 and IPv6 ranges.
// ----------------------------------------------------------------------------
module pac_fixed (
  input  logic        is_v6,
  input  logic [63:0] addr_high,
  input  logic [63:0] addr_low,
  output logic        hit
);

  localparam logic [7:0]  V4_TEN       = 8'd10;
  localparam logic [7:0]  V4_172       = 8'd172;
  localparam logic [7:0]  V4_LOOP      = 8'd127;
  localparam logic [15:0] V4_192_168   = 16'hc0a8;
  localparam logic [15:0] V4_169_254   = 16'ha9fe;
  localparam logic [7:0]  V6_LINK_B0   = 8'hfe;
  localparam logic [7:0]  V6_LINK_MASK = 8'hc0;
  localparam logic [7:0]  V6_LINK_B1   = 8'h80;
  localparam logic [7:0]  V6_ULA_MASK  = 8'hfe;
  localparam logic [7:0]  V6_ULA_B0    = 8'hfc;

  logic [7:0] v4_first;
  logic [7:0] v4_second;
  logic       v4_hit;
  logic [7:0] v6_b0;
  logic [7:0] v6_b1;
  logic       v6_hit;

  // IPv4: 10/8, 172.16/12, 192.168/16, 127/8, 169.254/16
  assign v4_first  = addr_low[31:24];
  assign v4_second = addr_low[23:16];
  assign v4_hit = (v4_first == V4_TEN) ||
                  (v4_first == V4_172 && v4_second[7:4] == 4'h1) ||
                  (addr_low[31:16] == V4_192_168) ||
                  (v4_first == V4_LOOP) ||
                  (addr_low[31:16] == V4_169_254);

  // IPv6: fe80::/10, fc00::/7, ::1
  assign v6_b0 = addr_high[63:56];
  assign v6_b1 = addr_high[55:48];
  assign v6_hit = (v6_b0 == V6_LINK_B0 && (v6_b1 & V6_LINK_MASK) == V6_LINK_B1) ||
                  ((v6_b0 & V6_ULA_MASK) == V6_ULA_B0) ||
                  (addr_high == 64'd0 && addr_low == 64'd1);

  assign hit = is_v6 ? v6_hit : v4_hit;

endmodule

### src/pac_cell.sv
// ----------------------------------------------------------------------------
// pac_cell
// One custom prefix entry. Holds a network and prefix, compares it with the
// broadcast query when the search token passes, and forwards token and hit.
// ----------------------------------------------------------------------------
module pac_cell #(
  parameter int IDX = 0,
  parameter int CW  = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  logic                wr_v6,
  input  logic [63:0]         wr_high,
  input  logic [63:0]         wr_low,
  input  logic [7:0]          wr_prefix,
  input  logic [CW-1:0]       count,
  input  logic                q_v6,
  input  logic [63:0]         q_high,
  input  logic [63:0]         q_low,
  input  pac_pkg::pac_link_t  link_in,
  output pac_pkg::pac_link_t  link_out
);

  logic [63:0] net_high;
  logic [63:0] net_low;
  logic [7:0]  prefix;
  logic        family;

  logic        occupied;
  logic [63:0] mask_high;
  logic [63:0] mask_low;
  logic [7:0]  low_bits;
  logic        v4_match;
  logic        v6_match;
  logic        match;

  // Mask of the top 'bits' bits of a 64-bit word
  function automatic logic [63:0] top_mask(input logic [7:0] bits);
    logic [63:0] m;
    for (int k = 0; k < 64; k++) begin
      m[63-k] = (8'(k) < bits);
    end
    return m;
  endfunction

  // Load the entry when selected
  always_ff @(posedge clk) begin
    if (wr) begin
      net_high <= wr_high;
      net_low  <= wr_low;
      prefix   <= wr_prefix;
      family   <= wr_v6;
    end
  end

  // Compare against the query
  assign occupied  = (count > CW'(IDX));
  assign low_bits  = (prefix > 8'd64) ? (prefix - 8'd64) : 8'd0;
  assign mask_high = top_mask(prefix);
  assign mask_low  = top_mask(low_bits);
  assign v4_match  = (((q_low[31:0] ^ net_low[31:0]) & mask_high[63:32]) == 32'd0);
  assign v6_match  = (((q_high ^ net_high) & mask_high) == 64'd0) &&
                     (((q_low ^ net_low) & mask_low) == 64'd0);
  assign match = occupied && (family == q_v6) &&
                 ((q_v6 == pac_pkg::FAM_V6) ? v6_match : v4_match);

  // Advance token and hit to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out <= '0;
    end else begin
      link_out.tok <= link_in.tok;
      link_out.hit <= link_in.hit | (link_in.tok & match);
    end
  end

endmodule

### src/private_address_classifier.sv
// ----------------------------------------------------------------------------
// private_address_classifier
// Flags IPv4/IPv6 addresses in fixed private ranges or in a loadable table
// of custom prefixes held in a chain of entry cells.
// ----------------------------------------------------------------------------
// One item is handled at a time. A load, or a classification that hits a
// fixed range, waits in the hold state until the output register is free.
// Any other classification sends a search token down the chain of
// TABLE_ENTRIES cells, one cell per cycle, and enters the hold state when
// the token leaves the last cell. A finished result sits in an output
// register, so the next item may be accepted while the result still waits
// to be taken.
module private_address_classifier #(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic        is_v6,
  input  logic [63:0] addr_high,
  input  logic [63:0] addr_low,
  input  logic [7:0]  prefix_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        addr_private,
  output logic        hit_custom,
  output logic        load_rejected
);

  `include "private_address_classifier_defines.svh"

  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t      state;
  logic [CW-1:0] count;
  logic        start;
  logic        q_v6;
  logic [63:0] q_high;
  logic [63:0] q_low;
  logic        pend_private;
  logic        pend_custom;
  logic        pend_rejected;

  logic        accept;
  logic        deliver;
  logic        fixed_hit;
  logic        prefix_bad;
  logic        table_full;
  logic        load_ok;
  logic        walk_begin;
  logic [63:0] wr_high;
  logic [63:0] wr_low;
  logic [TABLE_ENTRIES:0] tok_vec;

  pac_pkg::pac_link_t links [TABLE_ENTRIES+1];

  // Accept only when no item is in progress
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Present a held result once the output register is free
  assign deliver  = (state == ST_HOLD) && (!out_valid || !out_stall);

  pac_fixed u_fixed (
    .is_v6     (is_v6),
    .addr_high (addr_high),
    .addr_low  (addr_low),
    .hit       (fixed_hit)
  );

  // Load checks
  assign prefix_bad = (is_v6 == pac_pkg::FAM_V6) ? (prefix_length > pac_pkg::V6_PREFIX_MAX)
                                                 : (prefix_length > pac_pkg::V4_PREFIX_MAX);
  assign table_full = (count == CW'(TABLE_ENTRIES));
  assign load_ok    = accept && (action == pac_pkg::ACT_LOAD) && !prefix_bad && !table_full;
  assign walk_begin = accept && (action == pac_pkg::ACT_CLASSIFY) && !fixed_hit;

  // IPv4 entries keep the low 32 bits only
  assign wr_high = (is_v6 == pac_pkg::FAM_V6) ? addr_high : 64'd0;
  assign wr_low  = (is_v6 == pac_pkg::FAM_V6) ? addr_low : {32'd0, addr_low[31:0]};

  // Chain head: token registered together with the query capture
  assign links[0].tok = start;
  assign links[0].hit = 1'b0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    pac_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr        (load_ok && (count == CW'(i))),
      .wr_v6     (is_v6),
      .wr_high   (wr_high),
      .wr_low    (wr_low),
      .wr_prefix (prefix_length),
      .count     (count),
      .q_v6      (q_v6),
      .q_high    (q_high),
      .q_low     (q_low),
      .link_in   (links[i]),
      .link_out  (links[i+1])
    );
  end

  for (genvar i = 0; i <= TABLE_ENTRIES; i++) begin : g_tok
    assign tok_vec[i] = links[i].tok;
  end

  // Capture the query for the walk
  always_ff @(posedge clk) begin
    if (accept) begin
      q_v6   <= is_v6;
      q_high <= addr_high;
      q_low  <= addr_low;
    end
  end

  // Sequence items, count entries, hold and deliver results
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      start     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start <= walk_begin;
      if (load_ok) begin
        count <= count + CW'(1);
      end
      if (deliver) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (action == pac_pkg::ACT_LOAD) begin
              pend_private  <= 1'b0;
              pend_custom   <= 1'b0;
              pend_rejected <= !load_ok;
              state         <= ST_HOLD;
            end else if (fixed_hit) begin
              pend_private  <= 1'b1;
              pend_custom   <= 1'b0;
              pend_rejected <= 1'b0;
              state         <= ST_HOLD;
            end else begin
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (links[TABLE_ENTRIES].tok) begin
            pend_private  <= links[TABLE_ENTRIES].hit;
            pend_custom   <= links[TABLE_ENTRIES].hit;
            pend_rejected <= 1'b0;
            state         <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (deliver) begin
            addr_private  <= pend_private;
            hit_custom    <= pend_custom;
            load_rejected <= pend_rejected;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  `PAC_ASSERT_SAME(a_count_bound, 1'b1, count <= CW'(TABLE_ENTRIES), "entry count overflow")
  `PAC_ASSERT_NEXT(a_load_count, load_ok, count == $past(count) + CW'(1), "load lost")
  `PAC_ASSERT_SAME(a_one_token, 1'b1, $onehot0(tok_vec), "more than one search token")
  `PAC_ASSERT_NEXT(a_walk_end, (state == ST_WALK) && links[TABLE_ENTRIES].tok, state == ST_HOLD, "walk end missed")

endmodule
